### design/bclru_pkg.sv
package bclru_pkg;

   // Cache geometry and derived widths.
   localparam int SLOTS       = 16;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int MAX_RESULTS = 16;
   localparam int WBCNT_W     = $clog2(MAX_RESULTS + 1);

   // Packed stream widths, rounded up to whole bytes.
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 120;

   typedef enum logic [2:0] {
      OP_READ         = 3'd0,
      OP_WRITE        = 3'd1,
      OP_FLUSH_BLOCK  = 3'd2,
      OP_INVAL_BLOCK  = 3'd3,
      OP_INVAL_DEVICE = 3'd4,
      OP_FLUSH_ALL    = 3'd5
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_PICK,
      ST_APPLY,
      ST_EVICT,
      ST_ANSWER,
      ST_SWEEP,
      ST_SWEEP_END
   } state_type;

   // Which result the output register is loaded with.
   typedef enum logic [2:0] {
      OUT_NONE,
      OUT_FINAL,
      OUT_EVICT,
      OUT_PEND,
      OUT_PEND_LAST,
      OUT_EMPTY
   } out_kind_type;

   typedef struct packed {
      logic         load_req;
      logic         scan_step;
      logic         pick;
      logic         apply;
      logic         sweep_step;
      out_kind_type out_kind;
   } cmd_type;

   typedef struct packed {
      logic is_rw;
      logic is_blk;
      logic is_sweep;
      logic enabled;
      logic write_sync;
      logic scan_last;
      logic out_free;
      logic evict_now;
      logic sweep_wb;
      logic pend_valid;
   } status_type;

endpackage

### design/block_cache_lru_tag_controller_unit.sv
// Channel    Direction  Signals                            Contents
// req        in         req_tvalid/tready/tdata            one cache request
// rsp        out        rsp_tvalid/tready/tdata/tlast      one or more results per transaction
// csr        in         csr_we/csr_wdata                   cache enable
//
// A read or write searches the tags, visiting one slot per cycle through the shared tag
// compare; flush and invalidate of a block search the same way. A synced write that evicts
// a dirty block first answers with the eviction. Invalidate device and flush all sweep
// every slot; a disabled read or write and an unused opcode answer without a search.
// Each result waits while the rsp register is full, stalling the request.
// One request is in flight at a time. Reset is synchronous; it clears valid, dirty and
// counters at once and sets each slot's rank to its slot index.
module block_cache_lru_tag_controller_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // opcode[2:0], device_number[18:3], block_number[50:19], sync_now[51]
   input  logic [bclru_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status[0], hit[1], slot[5:2], writeback[6], writeback_device[22:7],
   // writeback_block[54:23], hit_total[86:55], miss_total[118:87]
   output logic [bclru_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic                             csr_wdata
);
   import bclru_pkg::*;

   cmd_type    cmd;
   status_type sts;

   bclru_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bclru_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### design/bclru_ctrl.sv
module bclru_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  bclru_pkg::status_type sts,
   output bclru_pkg::cmd_type    cmd
);
   import bclru_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            priority if (sts.is_rw && !sts.enabled) state_in = ST_ANSWER;
            else if (sts.is_rw || sts.is_blk)     state_in = ST_SCAN;
            else if (sts.is_sweep)                state_in = ST_SWEEP;
            else                                  state_in = ST_ANSWER;
         end
         ST_SCAN: begin
            if (sts.scan_last) state_in = ST_PICK;
         end
         ST_PICK: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (sts.is_rw && sts.write_sync && sts.evict_now) state_in = ST_EVICT;
            else                                               state_in = ST_ANSWER;
         end
         ST_EVICT: begin
            if (sts.out_free) state_in = ST_ANSWER;
         end
         ST_ANSWER: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         ST_SWEEP: begin
            if (!(sts.sweep_wb && sts.pend_valid && !sts.out_free) && sts.scan_last)
               state_in = ST_SWEEP_END;
         end
         ST_SWEEP_END: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd        = '0;
      cmd.out_kind = OUT_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         ST_DISPATCH: ;
         ST_SCAN:  cmd.scan_step = 1'b1;
         ST_PICK:  cmd.pick = 1'b1;
         ST_APPLY: cmd.apply = 1'b1;
         ST_EVICT: begin
            if (sts.out_free) cmd.out_kind = OUT_EVICT;
         end
         ST_ANSWER: begin
            if (sts.out_free) cmd.out_kind = OUT_FINAL;
         end
         ST_SWEEP: begin
            // A new write-back pushes the pending one out, which needs room.
            if (!(sts.sweep_wb && sts.pend_valid && !sts.out_free)) begin
               cmd.sweep_step = 1'b1;
               if (sts.sweep_wb && sts.pend_valid) cmd.out_kind = OUT_PEND;
            end
         end
         ST_SWEEP_END: begin
            if (sts.out_free) cmd.out_kind = sts.pend_valid ? OUT_PEND_LAST : OUT_EMPTY;
         end
         default: ;
      endcase
   end

endmodule

### design/bclru_dp.sv
module bclru_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [bclru_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                                csr_we,
   input  logic                                csr_wdata,
   input  bclru_pkg::cmd_type                  cmd,
   output bclru_pkg::status_type               sts,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bclru_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tlast
);
   import bclru_pkg::*;

   // Request fields held for the whole transaction.
   logic [2:0]  op_ff;
   logic [15:0] dev_ff;
   logic [31:0] blk_ff;
   logic        sync_ff;

   // Slot state.
   logic [15:0]       tag_dev_ff [SLOTS];
   logic [31:0]       tag_blk_ff [SLOTS];
   logic [SLOTS-1:0]  valid_ff, valid_in;
   logic [SLOTS-1:0]  dirty_ff, dirty_in;
   logic [SLOT_W-1:0] rank_ff [SLOTS];
   logic [SLOT_W-1:0] rank_in [SLOTS];
   logic [31:0]       hit_cnt_ff, miss_cnt_ff;
   logic              enable_ff;

   // Scan and decision registers.
   logic [SLOT_W-1:0] idx_ff;
   logic              hit_ff;
   logic [SLOT_W-1:0] hit_slot_ff;
   logic              free_ff;
   logic [SLOT_W-1:0] free_slot_ff;
   logic [SLOT_W-1:0] lru_slot_ff;
   logic [SLOT_W-1:0] lru_rank_ff;
   logic              wb_ff;
   logic [15:0]       wdev_ff;
   logic [31:0]       wblk_ff;

   // Pending write-back of a sweep, held until the next one or the end.
   logic              pend_valid_ff;
   logic [SLOT_W-1:0] pend_slot_ff;
   logic [15:0]       pend_dev_ff;
   logic [31:0]       pend_blk_ff;
   logic [WBCNT_W-1:0] wbcnt_ff;

   // Output register.
   logic              out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic              out_last_ff;

   logic              is_rw, is_blk, is_sweep;
   logic              cur_valid, cur_dirty, tag_eq, dev_eq;
   logic [15:0]       cur_dev;
   logic [31:0]       cur_blk;
   logic [SLOT_W-1:0] cur_rank;
   logic              scan_last, out_free, evict_now;
   logic              sw_match, sw_wb, sw_clear;
   logic [SLOT_W-1:0] pick_slot;

   // Result fields chosen for the output register.
   logic              r_status, r_hit, r_wb, r_last;
   logic [SLOT_W-1:0] r_slot;
   logic [15:0]       r_dev;
   logic [31:0]       r_blk;

   // Slot read at the scan index.
   assign cur_valid = valid_ff[idx_ff];
   assign cur_dirty = dirty_ff[idx_ff];
   assign cur_dev   = tag_dev_ff[idx_ff];
   assign cur_blk   = tag_blk_ff[idx_ff];
   assign cur_rank  = rank_ff[idx_ff];
   assign dev_eq    = cur_dev == dev_ff;
   assign tag_eq    = cur_valid && dev_eq && (cur_blk == blk_ff);

   assign is_rw    = (op_ff == OP_READ) || (op_ff == OP_WRITE);
   assign is_blk   = (op_ff == OP_FLUSH_BLOCK) || (op_ff == OP_INVAL_BLOCK);
   assign is_sweep = (op_ff == OP_INVAL_DEVICE) || (op_ff == OP_FLUSH_ALL);

   assign scan_last = idx_ff == SLOT_W'(SLOTS - 1);
   assign out_free  = !out_valid_ff || rsp_tready;
   assign evict_now = !hit_ff && !free_ff && cur_dirty;
   assign pick_slot = hit_ff ? hit_slot_ff : (free_ff ? free_slot_ff : lru_slot_ff);

   // Sweep decision for the slot at the scan index.
   assign sw_match = cur_valid && ((op_ff == OP_FLUSH_ALL) || dev_eq);
   assign sw_wb    = sw_match && cur_dirty && (wbcnt_ff < WBCNT_W'(MAX_RESULTS));
   assign sw_clear = sw_match && (op_ff == OP_INVAL_DEVICE) && (!cur_dirty || sw_wb);

   always_comb begin
      sts.is_rw      = is_rw;
      sts.is_blk     = is_blk;
      sts.is_sweep   = is_sweep;
      sts.enabled    = enable_ff;
      sts.write_sync = (op_ff == OP_WRITE) && sync_ff;
      sts.scan_last  = scan_last;
      sts.out_free   = out_free;
      sts.evict_now  = evict_now;
      sts.sweep_wb   = sw_wb;
      sts.pend_valid = pend_valid_ff;
   end

   // Next values of valid, dirty and recency state.
   always_comb begin
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      for (int j = 0; j < SLOTS; j++) begin
         rank_in[j] = rank_ff[j];
      end
      if (cmd.apply && is_rw) begin
         // Move the slot to the front; slots more recent than it age by one.
         for (int j = 0; j < SLOTS; j++) begin
            if (rank_ff[j] < cur_rank) rank_in[j] = rank_ff[j] + 1'b1;
         end
         rank_in[idx_ff]  = '0;
         valid_in[idx_ff] = 1'b1;
         // A write leaves the block dirty unless synced; a read hit keeps its state.
         if (op_ff == OP_WRITE) begin
            dirty_in[idx_ff] = !sync_ff;
         end else if (!hit_ff) begin
            dirty_in[idx_ff] = 1'b0;
         end
      end else if (cmd.apply && is_blk && hit_ff) begin
         dirty_in[idx_ff] = 1'b0;
         if (op_ff == OP_INVAL_BLOCK) valid_in[idx_ff] = 1'b0;
      end else if (cmd.sweep_step) begin
         if (sw_wb)    dirty_in[idx_ff] = 1'b0;
         if (sw_clear) valid_in[idx_ff] = 1'b0;
      end
   end

   // Result selection.
   always_comb begin
      r_status = 1'b0;
      r_hit    = 1'b0;
      r_slot   = '0;
      r_wb     = 1'b0;
      r_dev    = '0;
      r_blk    = '0;
      r_last   = 1'b1;
      unique case (cmd.out_kind)
         OUT_FINAL: begin
            priority if (is_rw && !enable_ff) begin
               r_status = 1'b1;
            end else if (is_rw) begin
               r_hit  = hit_ff;
               r_slot = idx_ff;
               if ((op_ff == OP_WRITE) && sync_ff) begin
                  r_wb  = 1'b1;
                  r_dev = dev_ff;
                  r_blk = blk_ff;
               end else if (wb_ff) begin
                  r_wb  = 1'b1;
                  r_dev = wdev_ff;
                  r_blk = wblk_ff;
               end
            end else if (is_blk && hit_ff) begin
               r_hit  = 1'b1;
               r_slot = idx_ff;
               if (wb_ff) begin
                  r_wb  = 1'b1;
                  r_dev = dev_ff;
                  r_blk = blk_ff;
               end
            end else begin
               r_hit = 1'b0;
            end
         end
         OUT_EVICT: begin
            r_hit  = hit_ff;
            r_slot = idx_ff;
            r_wb   = 1'b1;
            r_dev  = wdev_ff;
            r_blk  = wblk_ff;
            r_last = 1'b0;
         end
         OUT_PEND, OUT_PEND_LAST: begin
            r_slot = pend_slot_ff;
            r_wb   = 1'b1;
            r_dev  = pend_dev_ff;
            r_blk  = pend_blk_ff;
            r_last = cmd.out_kind == OUT_PEND_LAST;
         end
         OUT_NONE, OUT_EMPTY: ;
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         dirty_ff      <= '0;
         for (int j = 0; j < SLOTS; j++) begin
            rank_ff[j] <= SLOT_W'(j);
         end
         hit_cnt_ff    <= '0;
         miss_cnt_ff   <= '0;
         enable_ff     <= 1'b1;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         wbcnt_ff      <= '0;
         hit_ff        <= 1'b0;
         free_ff       <= 1'b0;
         wb_ff         <= 1'b0;
         idx_ff        <= '0;
      end else begin
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
         for (int j = 0; j < SLOTS; j++) begin
            rank_ff[j] <= rank_in[j];
         end
         if (csr_we) enable_ff <= csr_wdata;

         // New transaction: clear the scan.
         if (cmd.load_req) begin
            idx_ff        <= '0;
            hit_ff        <= 1'b0;
            free_ff       <= 1'b0;
            wb_ff         <= 1'b0;
            pend_valid_ff <= 1'b0;
            wbcnt_ff      <= '0;
         end

         // Tag search: first hit, lowest free slot, least recent slot.
         if (cmd.scan_step) begin
            idx_ff <= idx_ff + 1'b1;
            if (tag_eq && !hit_ff) hit_ff <= 1'b1;
            if (!cur_valid && !free_ff) free_ff <= 1'b1;
         end

         if (cmd.pick) idx_ff <= pick_slot;

         // Eviction or block flush decides whether a write-back is due.
         if (cmd.apply) begin
            if (is_rw) begin
               wb_ff <= evict_now;
               if (op_ff == OP_READ) begin
                  if (hit_ff) hit_cnt_ff  <= hit_cnt_ff + 1'b1;
                  else        miss_cnt_ff <= miss_cnt_ff + 1'b1;
               end
            end else begin
               wb_ff <= hit_ff && cur_dirty;
            end
         end

         if (cmd.sweep_step) begin
            idx_ff <= idx_ff + 1'b1;
            if (sw_wb) begin
               pend_valid_ff <= 1'b1;
               wbcnt_ff      <= wbcnt_ff + 1'b1;
            end
         end

         // Output register.
         if (cmd.out_kind != OUT_NONE) out_valid_ff <= 1'b1;
         else if (rsp_tready)          out_valid_ff <= 1'b0;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= req_tdata[2:0];
         dev_ff  <= req_tdata[18:3];
         blk_ff  <= req_tdata[50:19];
         sync_ff <= req_tdata[51];
      end
      if (cmd.scan_step) begin
         if (tag_eq && !hit_ff) hit_slot_ff <= idx_ff;
         if (!cur_valid && !free_ff) free_slot_ff <= idx_ff;
         if ((idx_ff == '0) || (cur_rank > lru_rank_ff)) begin
            lru_slot_ff <= idx_ff;
            lru_rank_ff <= cur_rank;
         end
      end
      if (cmd.apply && is_rw) begin
         wdev_ff <= cur_dev;
         wblk_ff <= cur_blk;
         tag_dev_ff[idx_ff] <= dev_ff;
         tag_blk_ff[idx_ff] <= blk_ff;
      end
      if (cmd.sweep_step && sw_wb) begin
         pend_slot_ff <= idx_ff;
         pend_dev_ff  <= cur_dev;
         pend_blk_ff  <= cur_blk;
      end
      if (cmd.out_kind != OUT_NONE) begin
         out_data_ff <= {1'b0, miss_cnt_ff, hit_cnt_ff, r_blk, r_dev, r_wb,
                         4'(r_slot), r_hit, r_status};
         out_last_ff <= r_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

### bench/tb.sv
module tb;
   import bclru_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // opcode[2:0], device_number[18:3], block_number[50:19], sync_now[51]
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // status[0], hit[1], slot[5:2], writeback[6], writeback_device[22:7],
   // writeback_block[54:23], hit_total[86:55], miss_total[118:87]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we;
   logic                  csr_wdata;

   typedef struct packed {
      logic        last;
      logic [31:0] miss_total;
      logic [31:0] hit_total;
      logic [31:0] wb_block;
      logic [15:0] wb_device;
      logic        writeback;
      logic [3:0]  slot;
      logic        hit;
      logic        status;
   } cache_result_t;

   block_cache_lru_tag_controller_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // Shadow copy of the cache tags, replacement ranks and counters.
   logic [15:0] shadow_dev [SLOTS];
   logic [31:0] shadow_blk [SLOTS];
   logic        shadow_valid [SLOTS];
   logic        shadow_dirty [SLOTS];
   logic [3:0]  shadow_rank [SLOTS];
   logic [31:0] shadow_hits;
   logic [31:0] shadow_misses;
   logic        shadow_enable;

   cache_result_t pending_results [$];
   int  error_count;
   int  sent_count;
   int  result_count;
   int  hold_off_cycles;
   bit  burst_mode;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Safety net in case the block locks up.
   initial begin
      #3000000;
      $display("block_cache_lru_tag_controller_unit verification failed");
      $finish;
   end

   function automatic cache_result_t make_result(logic st, logic h, int s, logic wb,
                                                  logic [15:0] d, logic [31:0] b,
                                                  logic lst);
      cache_result_t r;
      r.status     = st;
      r.hit        = h;
      r.slot       = s[3:0];
      r.writeback  = wb;
      r.wb_device  = wb ? d : 16'd0;
      r.wb_block   = wb ? b : 32'd0;
      r.hit_total  = shadow_hits;
      r.miss_total = shadow_misses;
      r.last       = lst;
      return r;
   endfunction

   function automatic int find_slot(logic [15:0] d, logic [31:0] b);
      for (int i = 0; i < SLOTS; i++)
         if (shadow_valid[i] && shadow_dev[i] == d && shadow_blk[i] == b) return i;
      return -1;
   endfunction

   // Move a slot to most recent, ageing every slot that was more recent.
   function automatic void make_recent(int s);
      logic [3:0] r;
      r = shadow_rank[s];
      for (int j = 0; j < SLOTS; j++)
         if (shadow_rank[j] < r) shadow_rank[j]++;
      shadow_rank[s] = 4'd0;
   endfunction

   // Work out every result of one request and update the shadow state.
   task automatic predict_request(logic [2:0] op, logic [15:0] d, logic [31:0] b,
                                  logic sync);
      int s, v, n;
      logic h, wb;
      logic [15:0] wd;
      logic [31:0] wbk;
      n = 0;
      if (op == OP_READ || op == OP_WRITE) begin
         if (!shadow_enable) begin
            pending_results.push_back(make_result(1, 0, 0, 0, 0, 0, 1));
            return;
         end
         s = find_slot(d, b);
         h = (s >= 0);
         wb = 0; wd = 0; wbk = 0;
         if (op == OP_READ) begin
            if (h) shadow_hits++;
            else shadow_misses++;
         end
         if (!h) begin
            s = -1;
            for (int i = 0; i < SLOTS; i++)
               if (s < 0 && !shadow_valid[i]) s = i;
            if (s < 0) begin
               v = 0;
               for (int i = 1; i < SLOTS; i++)
                  if (shadow_rank[i] > shadow_rank[v]) v = i;
               if (shadow_dirty[v]) begin
                  wb = 1; wd = shadow_dev[v]; wbk = shadow_blk[v];
               end
               s = v;
            end
            shadow_dev[s] = d;
            shadow_blk[s] = b;
            shadow_valid[s] = 1;
            shadow_dirty[s] = 0;
         end
         make_recent(s);
         if (op == OP_WRITE) begin
            shadow_dirty[s] = !sync;
            if (sync) begin
               if (wb) pending_results.push_back(make_result(0, h, s, 1, wd, wbk, 0));
               pending_results.push_back(make_result(0, h, s, 1, d, b, 1));
               return;
            end
         end
         pending_results.push_back(make_result(0, h, s, wb, wd, wbk, 1));
      end else if (op == OP_FLUSH_BLOCK || op == OP_INVAL_BLOCK) begin
         s = find_slot(d, b);
         if (s < 0) begin
            pending_results.push_back(make_result(0, 0, 0, 0, 0, 0, 1));
            return;
         end
         wb = shadow_dirty[s];
         shadow_dirty[s] = 0;
         if (op == OP_INVAL_BLOCK) shadow_valid[s] = 0;
         pending_results.push_back(make_result(0, 1, s, wb, d, b, 1));
      end else if (op == OP_INVAL_DEVICE || op == OP_FLUSH_ALL) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (shadow_valid[i] && (op == OP_FLUSH_ALL || shadow_dev[i] == d)) begin
               if (shadow_dirty[i] && n < MAX_RESULTS) begin
                  pending_results.push_back(make_result(0, 0, i, 1, shadow_dev[i],
                                                        shadow_blk[i], 0));
                  shadow_dirty[i] = 0;
                  n++;
               end
               if (op == OP_INVAL_DEVICE && !shadow_dirty[i]) shadow_valid[i] = 0;
            end
         end
         if (n == 0) pending_results.push_back(make_result(0, 0, 0, 0, 0, 0, 1));
         else pending_results[$].last = 1'b1;
      end else begin
         pending_results.push_back(make_result(0, 0, 0, 0, 0, 0, 1));
      end
   endtask

   // Offer one transaction and wait until it is taken; the shadow is updated
   // at acceptance so it stays in step with the block.
   task automatic send_request(logic [2:0] op, logic [15:0] d, logic [31:0] b,
                               logic sync);
      req_tdata  <= {4'd0, sync, b, d, op};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_request(op, d, b, sync);
      sent_count++;
      // Once valid is dropped, a gap always follows.
      if (!burst_mode || $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat (1 + $urandom_range(0, burst_mode ? 6 : 0)) @(posedge clock);
      end
   endtask

   task automatic go_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SLOTS + 10) @(posedge clock);
   endtask

   task automatic write_enable(logic value);
      go_quiet();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      shadow_enable = value;
   endtask

   // Receiver: random stalls, stretches of always ready, and long hold-offs.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_tready <= 1'b0;
      end else if (($urandom_range(0, 63) < 24) && (sent_count % 80 < 60)) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare every accepted result with the oldest expectation.
   always @(posedge clock) begin
      cache_result_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {1'b0, rsp_tdata[118:0]};
         got.last = rsp_tlast;
         result_count++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               $display("%0t: result mismatch expected %h actual %h", $time, want, got);
               error_count++;
            end
         end
      end
   end

   // Directed: field extremes, every opcode, misses and unused opcodes.
   task automatic test_directed();
      send_request(OP_READ, 16'hFFFF, 32'hFFFF_FFFF, 0);
      send_request(OP_READ, 16'hFFFF, 32'hFFFF_FFFF, 0);
      send_request(OP_WRITE, 16'h0000, 32'h0000_0000, 1);
      send_request(OP_WRITE, 16'h0001, 32'h8000_0000, 0);
      send_request(OP_FLUSH_BLOCK, 16'h0001, 32'h8000_0000, 0);
      send_request(OP_FLUSH_BLOCK, 16'h0001, 32'h8000_0000, 1);
      send_request(OP_FLUSH_BLOCK, 16'h0002, 32'h1234_5678, 0);
      send_request(OP_INVAL_BLOCK, 16'h0002, 32'h1234_5678, 0);
      send_request(OP_WRITE, 16'h0001, 32'h8000_0000, 0);
      send_request(OP_INVAL_BLOCK, 16'h0001, 32'h8000_0000, 0);
      send_request(OP_WRITE, 16'hAAAA, 32'h5555_5555, 0);
      send_request(OP_INVAL_DEVICE, 16'hAAAA, 32'h0, 0);
      send_request(OP_INVAL_DEVICE, 16'h7777, 32'h0, 0);
      send_request(OP_FLUSH_ALL, 16'h0, 32'h0, 0);
      send_request(3'd6, 16'h5555, 32'hAAAA_AAAA, 1);
      send_request(3'd7, 16'hFFFF, 32'hFFFF_FFFF, 0);
   endtask

   // Fill every slot dirty, then evict with and without sync, then sweep 16.
   task automatic test_eviction();
      for (int i = 0; i < SLOTS; i++)
         send_request(OP_WRITE, 16'h0100, i, 0);
      send_request(OP_WRITE, 16'h0200, 32'd1, 1);
      send_request(OP_READ, 16'h0200, 32'd2, 0);
      send_request(OP_WRITE, 16'h0200, 32'd3, 0);
      for (int i = 0; i < SLOTS; i++)
         send_request(OP_WRITE, 16'h0300, i, 0);
      send_request(OP_FLUSH_ALL, 16'h0, 32'h0, 0);
   endtask

   task automatic test_disabled();
      write_enable(1'b0);
      send_request(OP_READ, 16'h0300, 32'd1, 0);
      send_request(OP_WRITE, 16'h0300, 32'd2, 1);
      send_request(OP_FLUSH_BLOCK, 16'h0300, 32'd3, 0);
      write_enable(1'b1);
   endtask

   // Random traffic over a small tag space so hits, evictions and sweeps occur.
   task automatic test_random(int count);
      logic [2:0] op;
      int k;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(0, 99);
         op = k < 35 ? OP_READ : k < 70 ? OP_WRITE : k < 80 ? OP_FLUSH_BLOCK :
              k < 88 ? OP_INVAL_BLOCK : k < 93 ? OP_INVAL_DEVICE :
              k < 97 ? OP_FLUSH_ALL : 3'($urandom_range(6, 7));
         if (i % 10 == 0) burst_mode = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 9) == 0)
            send_request(op, 16'($urandom), $urandom, 1'($urandom_range(0, 1)));
         else
            send_request(op, 16'($urandom_range(0, 3)), $urandom_range(0, 24),
                         1'($urandom_range(0, 1)));
      end
   endtask

   // Long hold-off on the receiver while requests keep arriving.
   task automatic test_backpressure();
      hold_off_cycles = 400;
      for (int i = 0; i < 12; i++)
         send_request(OP_WRITE, 16'h0400, i, 1);
      go_quiet();
   endtask

   initial begin
      error_count = 0;
      sent_count = 0;
      result_count = 0;
      hold_off_cycles = 0;
      burst_mode = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_wdata = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         shadow_dev[i] = '0;
         shadow_blk[i] = '0;
         shadow_valid[i] = 1'b0;
         shadow_dirty[i] = 1'b0;
         shadow_rank[i] = i[3:0];
      end
      shadow_hits = '0;
      shadow_misses = '0;
      shadow_enable = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_enable(1'b1);
      test_directed();
      test_eviction();
      test_disabled();
      test_backpressure();
      test_random(130);
      go_quiet();
      test_random(110);
      go_quiet();

      $display("Sent %0d requests and checked %0d results, covering all opcodes,",
               sent_count, result_count);
      $display("LRU eviction, sweeps, the disabled cache and receiver back-pressure.");
      if (error_count == 0 && pending_results.size() == 0)
         $display("block_cache_lru_tag_controller_unit verification clean");
      else
         $display("block_cache_lru_tag_controller_unit verification failed");
      $finish;
   end
endmodule
